// File: hw/rtl/path_edge_setup_assert.svh
// ----------------------------------------------------------------------------
// Path edge setup assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PATH_EDGE_SETUP_ASSERT_SVH
`define PATH_EDGE_SETUP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PES_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path edge setup package
// Shared widths, codes and state types of the path edge setup block.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_ROWS   = 512;
    localparam int ROW_W      = 9;
    localparam int END_W      = 10;
    localparam int OFS_W      = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Floored y plus row offset, with room for the sum and the sign.
    localparam int PY_W = WORD_W - FRAC_BITS + 2;

    localparam logic [WORD_W-1:0] HALF_PIXEL = WORD_W'(1) << (FRAC_BITS - 1);
    localparam logic [END_W-1:0]  RASTER_ROWS_RESET = END_W'(MAX_ROWS);

    // Serial divider: two quotient bits per cycle.
    localparam int DIV_DIGIT  = 2;
    localparam int NUM_W      = WORD_W + FRAC_BITS;
    localparam int DIV_ITERS  = (NUM_W + DIV_DIGIT - 1) / DIV_DIGIT;
    localparam int NUM_PAD_W  = DIV_ITERS * DIV_DIGIT;
    localparam int DIV_CNT_W  = $clog2(DIV_ITERS + 1);

    // Serial multiplier: one four-bit digit of the multiplier per cycle.
    localparam int MUL_DIGIT  = 4;
    localparam int MUL_ITERS  = WORD_W / MUL_DIGIT;
    localparam int MUL_CNT_W  = $clog2(MUL_ITERS + 1);
    localparam int ACC_W      = WORD_W + FRAC_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_MOVE  = 2'd0,
        OP_LINE  = 2'd1,
        OP_CLOSE = 2'd2
    } pes_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_OFFSET    = 2'd0,
        CFG_COLUMN_OFFSET = 2'd1,
        CFG_RASTER_ROWS   = 2'd2
    } pes_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_PREP,
        ST_DIVIDE,
        ST_MULT,
        ST_FINISH
    } pes_state_t;

endpackage

// File: hw/rtl/pes_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path edge setup channels
// Valid/ready channels for path command words and edge words.
// ----------------------------------------------------------------------------
interface pes_cmd_if import pes_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;

    modport source (output valid, output opcode, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input opcode, input point_x, input point_y,
                    output ready);
endinterface

interface pes_edge_if import pes_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         first_row;
    logic [END_W-1:0]         end_row;
    logic signed [WORD_W-1:0] start_x;
    logic signed [WORD_W-1:0] x_step;
    logic                     upward;

    modport source (output valid, output first_row, output end_row, output start_x,
                    output x_step, output upward, input ready);
    modport sink   (input valid, input first_row, input end_row, input start_x,
                    input x_step, input upward, output ready);
endinterface

// File: hw/rtl/pes_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path edge setup divider
// Serial restoring divider for the x step: (dividend << FRAC_BITS) / divisor,
// truncated toward zero, low word of the quotient.
// ----------------------------------------------------------------------------
module pes_divider import pes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_PAD_W-1:0] num_reg, num_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;

    logic [WORD_W-1:0]    abs_dividend;
    logic [WORD_W-1:0]    abs_divisor;
    logic [NUM_PAD_W-1:0] num_t;
    logic [WORD_W-1:0]    rem_t;
    logic [WORD_W:0]      trial;

    assign abs_dividend = dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
    assign abs_divisor  = divisor[WORD_W-1] ? (~divisor + WORD_W'(1)) : divisor;

    // The numerator register shifts out dividend bits at the top while the
    // quotient bits shift in at the bottom.
    always_comb
    begin
        num_t = num_reg;
        rem_t = rem_reg;
        trial = '0;
        for (int i = 0; i < DIV_DIGIT; i++)
        begin
            trial = {rem_t, num_t[NUM_PAD_W-1]};
            num_t = {num_t[NUM_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial    = trial - {1'b0, dvs_reg};
                num_t[0] = 1'b1;
            end
            rem_t = trial[WORD_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_ITERS);
            num_next  = NUM_PAD_W'({abs_dividend, {FRAC_BITS{1'b0}}});
            rem_next  = '0;
            dvs_next  = abs_divisor;
            neg_next  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            num_next = num_t;
            rem_next = rem_t;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~num_reg[WORD_W-1:0] + WORD_W'(1)) : num_reg[WORD_W-1:0];

endmodule

// File: hw/rtl/pes_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path edge setup multiplier
// Digit-serial signed multiplier; returns the product shifted right by
// FRAC_BITS (floor), low word only.
// ----------------------------------------------------------------------------
module pes_multiplier import pes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] mcand,
    input  logic [WORD_W-1:0] mplier,
    output logic              done,
    output logic [WORD_W-1:0] product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     mcand_reg, mcand_next;
    logic [WORD_W-1:0]    mplier_reg, mplier_next;

    logic                           last_digit;
    logic signed [MUL_DIGIT:0]      digit_s;
    logic signed [ACC_W+MUL_DIGIT:0] term;

    // The top digit of the multiplier carries the sign weight.
    assign last_digit = (cnt_reg == MUL_CNT_W'(1));
    assign digit_s    = {last_digit & mplier_reg[MUL_DIGIT-1], mplier_reg[MUL_DIGIT-1:0]};
    assign term       = $signed(mcand_reg) * digit_s;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = MUL_CNT_W'(MUL_ITERS);
            acc_next    = '0;
            mcand_next  = ACC_W'($signed(mcand));
            mplier_next = mplier;
        end
        else if (busy_reg)
        begin
            acc_next    = acc_reg + term[ACC_W-1:0];
            mcand_next  = mcand_reg << MUL_DIGIT;
            mplier_next = mplier_reg >> MUL_DIGIT;
            cnt_next    = cnt_reg - MUL_CNT_W'(1);
            if (last_digit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg[ACC_W-1:FRAC_BITS];

endmodule

// File: hw/rtl/path_edge_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path edge setup
// Turns move, line and close path commands into clipped scanline edges.
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel, one word per move, line or close with a
// 16.16 point. Each command yields at most one edge word on the edges channel:
// first and end row, x at the center of the first row, x step per row and
// direction. A move while a path is open first yields the closing edge.
// Offsets and the raster height are set through the cfg write port; the user
// must write them only while the block is idle; the block does not enforce it.
// After a command is accepted, the block clips the rows of the edge, then
// computes the offset of the first row center and starts the divider, runs the
// divider (two quotient bits a cycle over the 48-bit numerator), starts the
// multiplier, runs it (one 4-bit digit a cycle), then picks up the product and
// loads the output register. cmd is ready again in the cycle after the load. A
// command that yields no edge leaves the block idle or returns it to idle from
// the clip step. One command is in work at a time; cmd is ready only between
// commands. The edge word sits in an output register, so the next command is
// taken while it waits; if the receiver stalls, a finished edge waits until
// the register frees up. Reset closes any path, zeroes the pen and start
// points and restores the registers to offsets 0 and 512 rows.
// ----------------------------------------------------------------------------
`include "path_edge_setup_assert.svh"

module path_edge_setup import pes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pes_cmd_if.sink               cmd,
    pes_edge_if.source            edges
);

    pes_state_t state_reg, state_next;

    logic signed [OFS_W-1:0] row_offset_reg, row_offset_next;
    logic signed [OFS_W-1:0] column_offset_reg, column_offset_next;
    logic [END_W-1:0]        raster_rows_reg, raster_rows_next;

    logic [WORD_W-1:0] start_px_reg, start_px_next;
    logic [WORD_W-1:0] start_py_reg, start_py_next;
    logic [WORD_W-1:0] pen_x_reg, pen_x_next;
    logic [WORD_W-1:0] pen_y_reg, pen_y_next;
    logic              path_active_reg, path_active_next;

    logic [WORD_W-1:0] ax_reg, ax_next;
    logic [WORD_W-1:0] ay_reg, ay_next;
    logic [WORD_W-1:0] bx_reg, bx_next;
    logic [WORD_W-1:0] by_reg, by_next;
    logic [WORD_W-1:0] x0_reg, x0_next;
    logic [WORD_W-1:0] y0_reg, y0_next;
    logic [WORD_W-1:0] x1_reg, x1_next;
    logic [WORD_W-1:0] y1_reg, y1_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [END_W-1:0]  bottom_reg, bottom_next;
    logic              up_reg, up_next;
    logic [WORD_W-1:0] sy_reg, sy_next;
    logic [WORD_W-1:0] step_reg, step_next;
    logic [WORD_W-1:0] start_x_reg, start_x_next;
    logic [ROW_W-1:0]  first_row_reg, first_row_next;
    logic [END_W-1:0]  end_row_reg, end_row_next;
    logic [WORD_W-1:0] x_step_reg, x_step_next;
    logic              upward_reg, upward_next;
    logic              out_valid_reg, out_valid_next;

    logic cmd_ready;
    logic div_start, div_done;
    logic mul_start, mul_done;
    logic [WORD_W-1:0] div_quotient;
    logic [WORD_W-1:0] mul_product;
    logic [WORD_W-1:0] dx, dy;

    logic signed [PY_W-1:0] py_a, py_b, py_lo, py_hi, height_s;
    logic [END_W-1:0]       height;
    logic                   swap;
    logic                   no_edge;
    logic [WORD_W-1:0]      row_diff;
    logic [WORD_W-1:0]      col_term;

    // Row clipping on the endpoints latched at command accept.
    assign py_a     = PY_W'(signed'(ay_reg[WORD_W-1:FRAC_BITS])) + PY_W'(row_offset_reg);
    assign py_b     = PY_W'(signed'(by_reg[WORD_W-1:FRAC_BITS])) + PY_W'(row_offset_reg);
    assign swap     = (py_a > py_b);
    assign py_lo    = swap ? py_b : py_a;
    assign py_hi    = swap ? py_a : py_b;
    assign height   = (raster_rows_reg > END_W'(MAX_ROWS)) ? END_W'(MAX_ROWS)
                                                           : raster_rows_reg;
    assign height_s = PY_W'(height);
    // A zero raster height leaves no row to cover.
    assign no_edge  = (py_a == py_b) || (py_hi <= 0) || (py_lo >= height_s) ||
                      (height == '0);

    assign dx       = x1_reg - x0_reg;
    assign dy       = y1_reg - y0_reg;
    assign row_diff = WORD_W'(top_reg) - WORD_W'(row_offset_reg);
    assign col_term = WORD_W'(column_offset_reg) << FRAC_BITS;

    always_comb
    begin
        state_next         = state_reg;
        row_offset_next    = row_offset_reg;
        column_offset_next = column_offset_reg;
        raster_rows_next   = raster_rows_reg;
        start_px_next      = start_px_reg;
        start_py_next      = start_py_reg;
        pen_x_next         = pen_x_reg;
        pen_y_next         = pen_y_reg;
        path_active_next   = path_active_reg;
        ax_next            = ax_reg;
        ay_next            = ay_reg;
        bx_next            = bx_reg;
        by_next            = by_reg;
        x0_next            = x0_reg;
        y0_next            = y0_reg;
        x1_next            = x1_reg;
        y1_next            = y1_reg;
        top_next           = top_reg;
        bottom_next        = bottom_reg;
        up_next            = up_reg;
        sy_next            = sy_reg;
        step_next          = step_reg;
        start_x_next       = start_x_reg;
        first_row_next     = first_row_reg;
        end_row_next       = end_row_reg;
        x_step_next        = x_step_reg;
        upward_next        = upward_reg;
        out_valid_next     = out_valid_reg && !edges.ready;
        cmd_ready          = 1'b0;
        div_start          = 1'b0;
        mul_start          = 1'b0;

        if (cfg_we)
        begin
            case (pes_cfg_t'(cfg_index))
                CFG_ROW_OFFSET:    row_offset_next    = cfg_data;
                CFG_COLUMN_OFFSET: column_offset_next = cfg_data;
                CFG_RASTER_ROWS:   raster_rows_next   = cfg_data[END_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd.valid)
                begin
                    // Endpoint A is always the pen; B is the new point or the start.
                    ax_next = pen_x_reg;
                    ay_next = pen_y_reg;
                    bx_next = start_px_reg;
                    by_next = start_py_reg;
                    case (pes_op_t'(cmd.opcode))
                        OP_MOVE:
                        begin
                            if (path_active_reg)
                            begin
                                state_next = ST_CLIP;
                            end
                            start_px_next    = cmd.point_x;
                            start_py_next    = cmd.point_y;
                            pen_x_next       = cmd.point_x;
                            pen_y_next       = cmd.point_y;
                            path_active_next = 1'b1;
                        end
                        OP_LINE:
                        begin
                            if (path_active_reg)
                            begin
                                bx_next    = cmd.point_x;
                                by_next    = cmd.point_y;
                                pen_x_next = cmd.point_x;
                                pen_y_next = cmd.point_y;
                                state_next = ST_CLIP;
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (path_active_reg)
                            begin
                                path_active_next = 1'b0;
                                state_next       = ST_CLIP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLIP:
            begin
                if (no_edge)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    x0_next     = swap ? bx_reg : ax_reg;
                    y0_next     = swap ? by_reg : ay_reg;
                    x1_next     = swap ? ax_reg : bx_reg;
                    y1_next     = swap ? ay_reg : by_reg;
                    up_next     = swap;
                    top_next    = (py_lo < 0) ? '0 : py_lo[ROW_W-1:0];
                    bottom_next = (py_hi > height_s) ? height : py_hi[END_W-1:0];
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                div_start  = 1'b1;
                // Offset of the first row center from the top endpoint.
                sy_next    = (row_diff << FRAC_BITS) + HALF_PIXEL - y0_reg;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    step_next  = div_quotient;
                    mul_start  = 1'b1;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                if (mul_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || edges.ready)
                begin
                    start_x_next   = x0_reg + mul_product + col_term;
                    first_row_next = top_reg;
                    end_row_next   = bottom_reg;
                    x_step_next    = step_reg;
                    upward_next    = up_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            row_offset_reg    <= '0;
            column_offset_reg <= '0;
            raster_rows_reg   <= RASTER_ROWS_RESET;
            start_px_reg      <= '0;
            start_py_reg      <= '0;
            pen_x_reg         <= '0;
            pen_y_reg         <= '0;
            path_active_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            row_offset_reg    <= row_offset_next;
            column_offset_reg <= column_offset_next;
            raster_rows_reg   <= raster_rows_next;
            start_px_reg      <= start_px_next;
            start_py_reg      <= start_py_next;
            pen_x_reg         <= pen_x_next;
            pen_y_reg         <= pen_y_next;
            path_active_reg   <= path_active_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        top_reg       <= top_next;
        bottom_reg    <= bottom_next;
        up_reg        <= up_next;
        sy_reg        <= sy_next;
        step_reg      <= step_next;
        start_x_reg   <= start_x_next;
        first_row_reg <= first_row_next;
        end_row_reg   <= end_row_next;
        x_step_reg    <= x_step_next;
        upward_reg    <= upward_next;
    end

    pes_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dx),
        .divisor  (dy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    pes_multiplier u_multiplier
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (div_quotient),
        .mplier  (sy_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    assign cmd.ready       = cmd_ready;
    assign edges.valid     = out_valid_reg;
    assign edges.first_row = first_row_reg;
    assign edges.end_row   = end_row_reg;
    assign edges.start_x   = start_x_reg;
    assign edges.x_step    = x_step_reg;
    assign edges.upward    = upward_reg;

    // The edge word has its own output register, so work on the next command
    // leaves a waiting word untouched.
    `PES_ASSERT_IMPLIES(a_div_done_state, div_done, state_reg == ST_DIVIDE, "stray divider done")
    `PES_ASSERT_IMPLIES(a_mul_done_state, mul_done, state_reg == ST_MULT, "stray multiplier done")
    `PES_ASSERT_IMPLIES(a_row_order, edges.valid, END_W'(edges.first_row) < edges.end_row, "empty rows")
    `PES_ASSERT_NEXT(a_one_command, cmd.valid && cmd.ready && state_next != ST_IDLE, !cmd.ready, "ready in work")

endmodule

// File: test/tb_path_edge_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path edge setup testbench
// Feeds move, line and close commands through the cmd channel and checks
// every edge word against an in-bench edge predictor. The run covers a short
// directed sequence, then random well-formed paths with some noise, under
// several register settings and idle patterns, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_path_edge_setup import pes_pkg::*; ();

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 72;
    localparam int REPORT_MAX    = 10;
    localparam logic [WORD_W-1:0] CORNERS [4] =
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [WORD_W-1:0] point_x;
        logic [WORD_W-1:0] point_y;
    } path_cmd_t;

    typedef struct packed {
        logic [ROW_W-1:0]  first_row;
        logic [END_W-1:0]  end_row;
        logic [WORD_W-1:0] start_x;
        logic [WORD_W-1:0] x_step;
        logic              upward;
    } edge_word_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  cmd_valid  = 1'b0;
    logic [OP_W-1:0]       cmd_opcode = '0;
    logic [WORD_W-1:0]     cmd_x      = '0;
    logic [WORD_W-1:0]     cmd_y      = '0;
    logic                  edge_ready = 1'b0;
    logic                  hold_go    = 1'b0;

    int hold_left      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;
    int mismatches     = 0;
    int accepted       = 0;
    int edges_seen     = 0;

    path_cmd_t  pending_cmds [$];
    edge_word_t edge_queue [$];

    // Predictor copy of the registers and of the path state.
    longint            row_ofs   = 0;
    longint            col_ofs   = 0;
    int                rows_reg  = MAX_ROWS;
    logic [WORD_W-1:0] origin_x  = '0;
    logic [WORD_W-1:0] origin_y  = '0;
    logic [WORD_W-1:0] pen_x     = '0;
    logic [WORD_W-1:0] pen_y     = '0;
    bit                path_live = 1'b0;

    pes_cmd_if  cmd_ch ();
    pes_edge_if edge_ch ();

    assign cmd_ch.valid   = cmd_valid;
    assign cmd_ch.opcode  = cmd_opcode;
    assign cmd_ch.point_x = cmd_x;
    assign cmd_ch.point_y = cmd_y;
    assign edge_ch.ready  = edge_ready;

    path_edge_setup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .edges     (edge_ch)
    );

    always #5 clk = ~clk;

    function automatic longint wrap32(input longint v);
        logic signed [WORD_W-1:0] w;
        w = v[WORD_W-1:0];
        return w;
    endfunction

    // Builds the clipped edge from point a to point b; returns 0 if dropped.
    function automatic bit trace_edge(input logic [WORD_W-1:0] ax, ay, bx, by,
                                      output edge_word_t e);
        longint height, x0, y0, x1, y1, py0, py1, t, top, bottom;
        longint dx, dy, step, sy, prod, xs;
        bit     up;
        e = '0;
        up = 1'b0;
        height = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        x0 = $signed(ax);
        y0 = $signed(ay);
        x1 = $signed(bx);
        y1 = $signed(by);
        py0 = (y0 >>> FRAC_BITS) + row_ofs;
        py1 = (y1 >>> FRAC_BITS) + row_ofs;
        if (py0 == py1)
            return 1'b0;
        if (py0 > py1)
        begin
            t = x0;  x0 = x1;   x1 = t;
            t = y0;  y0 = y1;   y1 = t;
            t = py0; py0 = py1; py1 = t;
            up = 1'b1;
        end
        if (py1 <= 0 || py0 >= height)
            return 1'b0;
        top    = (py0 < 0) ? 0 : py0;
        bottom = (py1 > height) ? height : py1;
        if (top >= bottom)
            return 1'b0;
        dy = wrap32(y1 - y0);
        dx = wrap32(x1 - x0);
        step = 0;
        if (dy != 0)
            step = wrap32((dx * (64'sd1 <<< FRAC_BITS)) / dy);
        // Sample point is the center of the first row, back in path units.
        sy   = wrap32(((top - row_ofs) <<< FRAC_BITS) + (64'sd1 <<< (FRAC_BITS - 1)));
        sy   = wrap32(sy - y0);
        prod = wrap32((step * sy) >>> FRAC_BITS);
        xs   = x0 + prod + (col_ofs <<< FRAC_BITS);
        e.first_row = top[ROW_W-1:0];
        e.end_row   = bottom[END_W-1:0];
        e.start_x   = xs[WORD_W-1:0];
        e.x_step    = step[WORD_W-1:0];
        e.upward    = up;
        return 1'b1;
    endfunction

    task automatic apply_command(input path_cmd_t c);
        edge_word_t e;
        bit         hit;
        hit = 1'b0;
        case (c.opcode)
            OP_MOVE:
            begin
                if (path_live)
                    hit = trace_edge(pen_x, pen_y, origin_x, origin_y, e);
                origin_x  = c.point_x;
                origin_y  = c.point_y;
                pen_x     = c.point_x;
                pen_y     = c.point_y;
                path_live = 1'b1;
            end
            OP_LINE:
            begin
                if (path_live)
                begin
                    hit = trace_edge(pen_x, pen_y, c.point_x, c.point_y, e);
                    pen_x = c.point_x;
                    pen_y = c.point_y;
                end
            end
            OP_CLOSE:
            begin
                if (path_live)
                begin
                    hit = trace_edge(pen_x, pen_y, origin_x, origin_y, e);
                    path_live = 1'b0;
                end
            end
            default: ;
        endcase
        if (hit)
            edge_queue.push_back(e);
    endtask

    // Command driver: holds a word until it is taken, then maybe idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && cmd_ch.ready)
            begin
                apply_command(pending_cmds.pop_front());
                accepted++;
            end
            if (!cmd_valid || cmd_ch.ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_valid  <= 1'b1;
                    cmd_opcode <= pending_cmds[0].opcode;
                    cmd_x      <= pending_cmds[0].point_x;
                    cmd_y      <= pending_cmds[0].point_y;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_ready <= 1'b0;
        else
            edge_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Edge monitor: every taken word must match the oldest predicted edge.
    always @(posedge clk)
    begin
        edge_word_t want;
        edge_word_t got;
        if (rst_n && edge_ch.valid && edge_ready)
        begin
            got.first_row = edge_ch.first_row;
            got.end_row   = edge_ch.end_row;
            got.start_x   = edge_ch.start_x;
            got.x_step    = edge_ch.x_step;
            got.upward    = edge_ch.upward;
            edges_seen++;
            if (edge_queue.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("cycle %0d: edge word arrived with none predicted", cycles);
                mismatches++;
            end
            else
            begin
                want = edge_queue.pop_front();
                if (got.first_row !== want.first_row || got.end_row !== want.end_row ||
                    got.start_x !== want.start_x || got.x_step !== want.x_step ||
                    got.upward !== want.upward)
                begin
                    if (mismatches < REPORT_MAX)
                        $display({"cycle %0d: edge rows %0d..%0d x %h step %h up %0b, ",
                                  "expected rows %0d..%0d x %h step %h up %0b"},
                                 cycles, got.first_row, got.end_row, got.start_x,
                                 got.x_step, got.upward, want.first_row, want.end_row,
                                 want.start_x, want.x_step, want.upward);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle %0d with %0d edges outstanding",
                     cycles, edge_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input pes_cfg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ROW_OFFSET:    row_ofs  = longint'($signed(value[OFS_W-1:0]));
            CFG_COLUMN_OFFSET: col_ofs  = longint'($signed(value[OFS_W-1:0]));
            CFG_RASTER_ROWS:   rows_reg = int'(value[END_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic apply_config(input int ro, input int co, input int rr);
        write_reg(CFG_ROW_OFFSET, CFG_DATA_W'(ro));
        write_reg(CFG_COLUMN_OFFSET, CFG_DATA_W'(co));
        write_reg(CFG_RASTER_ROWS, CFG_DATA_W'(rr));
    endtask

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] x, y);
        path_cmd_t c;
        c.opcode  = op;
        c.point_x = x;
        c.point_y = y;
        pending_cmds.push_back(c);
    endtask

    // Waits until every command is taken and every edge has come, then lets
    // a command that yields no edge finish as well.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd_valid || edge_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly points whose rows land near the raster, so edges survive clipping.
    function automatic void pick_point(input logic [WORD_W-1:0] last_y,
                                       output logic [WORD_W-1:0] x, y);
        int h, row, xpix, mode;
        h = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        if (h == 0)
            h = 1;
        mode = $urandom_range(99);
        row  = int'($urandom_range(h + 15)) - 8 - int'(row_ofs);
        xpix = int'($urandom_range(2047)) - 1024;
        x = {xpix[15:0], 16'($urandom)};
        y = {row[15:0], 16'($urandom)};
        if (mode < 10)
        begin
            y = {last_y[WORD_W-1:FRAC_BITS], 16'($urandom)};
        end
        else if (mode < 20)
        begin
            x = CORNERS[$urandom_range(3)];
            y = CORNERS[$urandom_range(3)];
        end
        else if (mode < 32)
        begin
            x = $urandom;
            y = $urandom;
        end
    endfunction

    task automatic queue_random_paths(input int budget);
        int                made, ending;
        logic [WORD_W-1:0] x, y, last_y;
        made   = 0;
        last_y = '0;
        while (made < budget)
        begin
            if ($urandom_range(99) < 12)
            begin
                // Noise: any opcode at any point, often with no path open.
                push_cmd(OP_W'($urandom_range(3)), $urandom, $urandom);
            end
            else
            begin
                pick_point(last_y, x, y);
                push_cmd(OP_MOVE, x, y);
                last_y = y;
                made++;
                repeat ($urandom_range(1, 6))
                begin
                    pick_point(last_y, x, y);
                    push_cmd(OP_LINE, x, y);
                    last_y = y;
                    made++;
                end
                // Either close, leave the path open for the next move to
                // close, or close and follow with a stray line.
                ending = $urandom_range(2);
                if (ending != 1)
                begin
                    push_cmd(OP_CLOSE, $urandom, $urandom);
                    made++;
                end
                if (ending == 2)
                    push_cmd(OP_LINE, $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        int ro, co, rr;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        apply_config(0, 0, MAX_ROWS);

        push_cmd(OP_LINE,   32'h7FFF_FFFF, 32'h8000_0000);
        push_cmd(OP_CLOSE,  32'h1234_5678, 32'h0001_0000);
        push_cmd(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(OP_MOVE,   32'h000A_8000, 32'h0002_4000);
        push_cmd(OP_LINE,   32'h0064_0000, 32'h0032_C000);
        push_cmd(OP_LINE,   32'h0064_0000, 32'h0032_1999);
        push_cmd(OP_LINE,   32'hFFFD_0000, 32'hFFFB_0000);
        push_cmd(OP_CLOSE,  32'h0000_0000, 32'h0000_0000);
        push_cmd(OP_LINE,   32'h0005_0000, 32'h0009_0000);
        push_cmd(OP_MOVE,   32'h0000_0000, 32'h0000_0000);
        push_cmd(OP_LINE,   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_cmd(OP_MOVE,   32'h8000_0000, 32'h8000_0000);
        push_cmd(OP_LINE,   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_cmd(OP_LINE,   32'h0000_0000, 32'h0258_0000);
        push_cmd(OP_LINE,   32'h0005_0000, 32'hFFF6_0000);
        push_cmd(OP_LINE,   32'h0007_0000, 32'hFFFD_0000);
        push_cmd(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);
        push_cmd(OP_CLOSE,  32'h0000_0000, 32'h0000_0000);
        push_cmd(OP_MOVE,   32'h1234_5678, 32'h0001_8000);
        push_cmd(OP_LINE,   32'hFFFF_0000, 32'h0005_0000);
        push_cmd(OP_MOVE,   32'h0020_0000, 32'h01FF_FFFF);
        push_cmd(OP_LINE,   32'hFFE0_0000, 32'h0000_0000);
        push_cmd(OP_CLOSE,  32'h0000_0000, 32'h0000_0000);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin ro = 0;      co = 0;      rr = MAX_ROWS; end
                1: begin ro = -32768; co = 32767;  rr = 1;        end
                2: begin ro = 32767;  co = -32768; rr = MAX_ROWS; end
                3: begin ro = 3;      co = -7;     rr = 240;      end
                4: begin ro = -40;    co = 100;    rr = 1023;     end
                5:
                begin
                    ro = int'($urandom_range(65535)) - 32768;
                    co = int'($urandom_range(65535)) - 32768;
                    rr = 0;
                end
                6:
                begin
                    ro = int'($urandom_range(40)) - 20;
                    co = int'($urandom_range(65535)) - 32768;
                    rr = $urandom_range(1, MAX_ROWS);
                end
                default: begin ro = 0; co = 0; rr = 16; end
            endcase
            apply_config(ro, co, rr);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            queue_random_paths(PHASE_ITEMS / 2);
            wait_idle();
            queue_random_paths(PHASE_ITEMS - PHASE_ITEMS / 2);
            if (p == 4)
            begin
                // Receiver holds off while commands keep coming, so the block
                // fills its output register and stops taking commands.
                @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            wait_idle();
        end

        $display("Checked %0d edge words from %0d commands over %0d register settings,",
                 edges_seen, accepted, PHASES + 1);
        $display("including zero and over-range raster heights, four idle mixes and a hold-off.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/pes_pkg.sv
hw/rtl/pes_if.sv
hw/rtl/pes_divider.sv
hw/rtl/pes_multiplier.sv
hw/rtl/path_edge_setup.sv
test/tb_path_edge_setup.sv
